/* rtl/assert_macros.svh */
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

/* rtl/aipr_pkg.sv */
`timescale 1ns / 1ps
package aipr_pkg;
  localparam int MAX_PAGES  = 256;
  localparam int PAGE_BITS  = $clog2(MAX_PAGES);
  localparam int LEN_BITS   = PAGE_BITS + 1;
  localparam int COUNT_BITS = 16;

  localparam logic [1:0] REG_PAGE_COUNT = 2'd0;

  localparam logic [1:0] KIND_ACCESS = 2'd0;
  localparam logic [1:0] KIND_SCAN   = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] ST_HIT_ACT   = 2'd0;
  localparam logic [1:0] ST_HIT_INACT = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_DONE      = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] page_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  moved_count;
    logic [8:0]  active_size;
    logic [8:0]  inactive_size;
    logic [15:0] reference_total;
  } out_word_t;
endpackage

/* rtl/active_inactive_page_reclaim_unit.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Two-list active/inactive page reclaim unit. Each page sits in a doubly
// linked list (prev/next pointer memories) plus a per-page record memory
// holding list membership, reference bit and saturating counter. An access
// unlinks and relinks its page at the active tail; when the active list then
// holds more than seven tenths of the pages, a drain walks the active head,
// moving pages to the inactive tail. A scan walks the whole active list.
// After reset or a page_count write, a clearing pass over the pages rebuilds
// the lists (the inactive list as pages in order) before any word is
// accepted. One word is in work at a time; the result sits in an output
// register, and the next word is taken only once that result is accepted or
// is accepted in the same cycle.
module active_inactive_page_reclaim_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  aipr_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aipr_pkg::out_word_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam int PB = aipr_pkg::PAGE_BITS;
  localparam int LB = aipr_pkg::LEN_BITS;
  localparam int CB = aipr_pkg::COUNT_BITS;
  localparam int RW = CB + 2;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_RD_REC, S_RD_WAIT, S_ACC_PN, S_ACC_WAIT, S_UNL_P, S_UNL_N,
    S_APP, S_APP_T, S_DRN_CHK, S_DRN_RD, S_DRN_WAIT, S_DRN_MV, S_DRN_L,
    S_SCN_CHK, S_SCN_RD, S_SCN_WAIT, S_SCN_WR, S_OUT
  } state_t;

  state_t state;
  logic [8:0] page_count;
  logic [LB-1:0] n_eff, init_idx, act_len, ina_len, drn_left;
  logic [PB-1:0] act_head, act_tail, ina_head, ina_tail, pg, cur, pp, pn;
  logic was_act, cfg_wr;
  logic at_head, at_tail;
  logic [7:0] moved;
  logic [1:0] status;
  logic [CB-1:0] total;

  // record: {in_active, ref_bit, counter}
  logic rec_we; logic [PB-1:0] rec_wa, rec_ra; logic [RW-1:0] rec_wd, rec_rd;
  logic nx_we;  logic [PB-1:0] nx_wa, nx_ra;   logic [PB-1:0] nx_wd, nx_rd;
  logic pv_we;  logic [PB-1:0] pv_wa, pv_ra;   logic [PB-1:0] pv_wd, pv_rd;

  aipr_ram #(.WIDTH(RW), .DEPTH(aipr_pkg::MAX_PAGES)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_wa), .wdata(rec_wd), .raddr(rec_ra), .rdata(rec_rd));
  aipr_ram #(.WIDTH(PB), .DEPTH(aipr_pkg::MAX_PAGES)) u_nxt (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
  aipr_ram #(.WIDTH(PB), .DEPTH(aipr_pkg::MAX_PAGES)) u_prv (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));

  assign pready = 1'b1;
  assign prdata = {23'd0, page_count};
  assign cfg_wr = psel && penable && pwrite && (paddr == aipr_pkg::REG_PAGE_COUNT);
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign n_eff = (page_count > 9'(aipr_pkg::MAX_PAGES)) ?
                 LB'(aipr_pkg::MAX_PAGES) : LB'(page_count);

  logic [LB+3:0] trig_l, trig_r;
  assign trig_l = (LB+4)'(act_len) * (LB+4)'(10);
  assign trig_r = (LB+4)'(n_eff) * (LB+4)'(7);
  logic [LB-1:0] div5;
  assign div5 = LB'((17'(act_len) * 17'd205) >> 10);

  always_comb begin
    rec_we = 1'b0; rec_wa = pg; rec_wd = rec_rd;
    nx_we = 1'b0; nx_wa = pg; nx_wd = pg;
    pv_we = 1'b0; pv_wa = pg; pv_wd = pg;
    rec_ra = pg; nx_ra = pg; pv_ra = pg;
    unique case (state)
      S_INIT: begin
        rec_we = 1'b1; rec_wa = init_idx[PB-1:0]; rec_wd = '0;
        nx_we = 1'b1; nx_wa = init_idx[PB-1:0]; nx_wd = PB'(init_idx + 1'b1);
        pv_we = 1'b1; pv_wa = init_idx[PB-1:0]; pv_wd = PB'(init_idx - 1'b1);
      end
      S_IDLE: begin
        rec_ra = in_data.page_id[PB-1:0]; nx_ra = in_data.page_id[PB-1:0];
        pv_ra = in_data.page_id[PB-1:0];
      end
      S_UNL_P: begin
        nx_we = !at_head; nx_wa = pp; nx_wd = pn;
      end
      S_UNL_N: begin
        pv_we = !at_tail; pv_wa = pn; pv_wd = pp;
      end
      S_APP: begin
        rec_we = 1'b1; rec_wa = pg; rec_wd = {2'b11, rec_rd[CB-1:0]};
        pv_we = 1'b1; pv_wa = pg; pv_wd = act_tail;
      end
      S_APP_T: begin
        nx_we = 1'b1; nx_wa = act_tail; nx_wd = pg;
      end
      S_DRN_RD, S_DRN_WAIT: begin
        rec_ra = cur; nx_ra = cur;
      end
      S_DRN_MV: begin
        rec_we = 1'b1; rec_wa = cur; rec_wd = {1'b0, rec_rd[CB:0]};
        pv_we = 1'b1; pv_wa = cur; pv_wd = ina_tail;
      end
      S_DRN_L: begin
        nx_we = 1'b1; nx_wa = ina_tail; nx_wd = cur;
      end
      S_SCN_RD, S_SCN_WAIT: begin
        rec_ra = cur; nx_ra = cur;
      end
      S_SCN_WR: begin
        rec_we = 1'b1; rec_wa = cur;
        rec_wd = {2'b10, rec_rd[CB-1:0] +
                  CB'(rec_rd[CB] && (rec_rd[CB-1:0] != '1))};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; page_count <= 9'd256; init_idx <= '0;
      act_len <= '0; ina_len <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_wr) begin
        page_count <= pwdata[8:0];
        state <= S_INIT; init_idx <= '0; act_len <= '0; ina_len <= '0;
      end else begin
        unique case (state)
          S_INIT: begin
            if (init_idx >= n_eff) begin
              act_len <= '0; ina_len <= n_eff;
              ina_head <= '0; ina_tail <= PB'(n_eff - 1'b1);
              state <= S_IDLE;
            end else begin
              init_idx <= init_idx + 1'b1;
            end
          end
          S_IDLE: begin
            if (in_valid && !in_stall) begin
              pg <= in_data.page_id[PB-1:0];
              moved <= '0; total <= '0; status <= aipr_pkg::ST_DONE;
              if (in_data.kind == aipr_pkg::KIND_ACCESS) begin
                if (LB'(in_data.page_id) >= n_eff) begin
                  status <= aipr_pkg::ST_RANGE; state <= S_OUT;
                end else state <= S_ACC_WAIT;
              end else if (in_data.kind == aipr_pkg::KIND_READ) begin
                if (LB'(in_data.page_id) >= n_eff) begin
                  status <= aipr_pkg::ST_RANGE; state <= S_OUT;
                end else state <= S_RD_WAIT;
              end else if (in_data.kind == aipr_pkg::KIND_SCAN) begin
                cur <= act_head; drn_left <= act_len; state <= S_SCN_CHK;
              end else state <= S_OUT;
            end
          end
          S_RD_REC: state <= S_RD_WAIT;
          S_RD_WAIT: begin
            total <= rec_rd[CB-1:0]; state <= S_OUT;
          end
          S_ACC_WAIT: begin
            was_act <= rec_rd[RW-1]; pp <= pv_rd; pn <= nx_rd;
            at_head <= rec_rd[RW-1] ? (act_head == pg) : (ina_head == pg);
            at_tail <= rec_rd[RW-1] ? (act_tail == pg) : (ina_tail == pg);
            status <= rec_rd[RW-1] ? aipr_pkg::ST_HIT_ACT : aipr_pkg::ST_HIT_INACT;
            state <= S_ACC_PN;
          end
          S_ACC_PN: begin
            // head/tail bookkeeping for unlink
            if (was_act) begin
              act_len <= act_len - 1'b1;
              if (act_head == pg) act_head <= pn;
              if (act_tail == pg) act_tail <= pp;
            end else begin
              ina_len <= ina_len - 1'b1;
              if (ina_head == pg) ina_head <= pn;
              if (ina_tail == pg) ina_tail <= pp;
            end
            state <= S_UNL_P;
          end
          S_UNL_P: state <= S_UNL_N;
          S_UNL_N: state <= S_APP;
          S_APP: begin
            if (act_len == '0) begin
              act_head <= pg; act_tail <= pg; state <= S_DRN_CHK;
            end else state <= S_APP_T;
            act_len <= act_len + 1'b1;
          end
          S_APP_T: begin
            act_tail <= pg; state <= S_DRN_CHK;
          end
          S_DRN_CHK: begin
            if (trig_l > trig_r) begin
              drn_left <= (div5 == '0) ? LB'(1) : div5;
              moved <= 8'((div5 == '0) ? LB'(1) : div5);
              cur <= act_head; state <= S_DRN_RD;
            end else state <= S_OUT;
          end
          S_DRN_RD: state <= S_DRN_WAIT;
          S_DRN_WAIT: state <= S_DRN_MV;
          S_DRN_MV: begin
            act_head <= nx_rd; act_len <= act_len - 1'b1;
            if (ina_len == '0) begin
              ina_head <= cur; ina_tail <= cur; ina_len <= LB'(1);
              drn_left <= drn_left - 1'b1;
              state <= (drn_left == LB'(1)) ? S_OUT : S_DRN_RD;
              cur <= nx_rd;
            end else state <= S_DRN_L;
            pn <= nx_rd;
          end
          S_DRN_L: begin
            ina_tail <= cur; ina_len <= ina_len + 1'b1;
            drn_left <= drn_left - 1'b1; cur <= pn;
            state <= (drn_left == LB'(1)) ? S_OUT : S_DRN_RD;
          end
          S_SCN_CHK: state <= (drn_left == '0) ? S_OUT : S_SCN_RD;
          S_SCN_RD: state <= S_SCN_WAIT;
          S_SCN_WAIT: state <= S_SCN_WR;
          S_SCN_WR: begin
            cur <= nx_rd; drn_left <= drn_left - 1'b1; state <= S_SCN_CHK;
          end
          S_OUT: begin
            out_valid <= 1'b1;
            out_data.status <= status;
            out_data.moved_count <= moved;
            out_data.active_size <= 9'(act_len);
            out_data.inactive_size <= 9'(ina_len);
            out_data.reference_total <= 16'(total);
            state <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  `ASSERT_CLK(a_len_sum, clk, rst, (state == S_IDLE) |-> (act_len + ina_len == n_eff), "list sizes do not add up")
  `ASSERT_CLK(a_no_take_busy, clk, rst, (state != S_IDLE) |-> in_stall, "word taken while busy")
  `ASSERT_CLK(a_out_from_out, clk, rst, $rose(out_valid) |-> $past(state == S_OUT), "result raised outside output state")
endmodule

/* rtl/aipr_ram.sv */
`timescale 1ns / 1ps
module aipr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* dv/reclaim_checker.sv */
`timescale 1ns / 1ps
module reclaim_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  aipr_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  aipr_pkg::out_word_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  pending
);
  int unsigned         pages_cfg;
  int unsigned         act_list[$];
  int unsigned         inact_list[$];
  bit                  ref_bit[aipr_pkg::MAX_PAGES];
  int unsigned         hit_count[aipr_pkg::MAX_PAGES];
  aipr_pkg::out_word_t expected_q[$];

  function automatic int unsigned page_limit();
    return (pages_cfg > aipr_pkg::MAX_PAGES) ? aipr_pkg::MAX_PAGES : pages_cfg;
  endfunction

  task automatic rebuild_lists();
    act_list.delete();
    inact_list.delete();
    for (int i = 0; i < aipr_pkg::MAX_PAGES; i++) begin
      ref_bit[i] = 0;
      hit_count[i] = 0;
    end
    for (int unsigned i = 0; i < page_limit(); i++) inact_list.push_back(i);
  endtask

  function automatic aipr_pkg::out_word_t predict_word(aipr_pkg::in_word_t w);
    aipr_pkg::out_word_t r;
    int unsigned n, pg, mv;
    bit found;
    n = page_limit();
    pg = {24'd0, w.page_id};
    r = '0;
    r.status = aipr_pkg::ST_DONE;
    if (w.kind == aipr_pkg::KIND_ACCESS) begin
      if (pg >= n) begin
        r.status = aipr_pkg::ST_RANGE;
      end else begin
        found = 0;
        for (int i = 0; i < act_list.size() && !found; i++) begin
          if (act_list[i] == pg) begin
            act_list.delete(i);
            found = 1;
            r.status = aipr_pkg::ST_HIT_ACT;
          end
        end
        for (int i = 0; i < inact_list.size() && !found; i++) begin
          if (inact_list[i] == pg) begin
            inact_list.delete(i);
            found = 1;
            r.status = aipr_pkg::ST_HIT_INACT;
          end
        end
        act_list.push_back(pg);
        ref_bit[pg] = 1;
        if (act_list.size() * 10 > n * 7) begin
          mv = act_list.size() / 5;
          if (mv < 1) mv = 1;
          for (int unsigned i = 0; i < mv; i++) inact_list.push_back(act_list.pop_front());
          r.moved_count = 8'(mv);
        end
      end
    end else if (w.kind == aipr_pkg::KIND_SCAN) begin
      foreach (act_list[i]) begin
        if (ref_bit[act_list[i]] && hit_count[act_list[i]] < 65535)
          hit_count[act_list[i]]++;
        ref_bit[act_list[i]] = 0;
      end
    end else if (w.kind == aipr_pkg::KIND_READ) begin
      if (pg >= n) r.status = aipr_pkg::ST_RANGE;
      else r.reference_total = 16'(hit_count[pg]);
    end
    r.active_size = 9'(act_list.size());
    r.inactive_size = 9'(inact_list.size());
    return r;
  endfunction

  always @(posedge clk) begin
    aipr_pkg::out_word_t e;
    if (rst) begin
      pages_cfg = 256;
      rebuild_lists();
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == aipr_pkg::REG_PAGE_COUNT) begin
        pages_cfg = {23'd0, pwdata[8:0]};
        rebuild_lists();
      end
      if (in_valid && !in_stall) expected_q.push_back(predict_word(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected word %h", out_data);
        end else begin
          e = expected_q.pop_front();
          if (e != out_data) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp st=%0d mv=%0d act=%0d inact=%0d tot=%0d got st=%0d mv=%0d act=%0d inact=%0d tot=%0d",
                e.status, e.moved_count, e.active_size, e.inactive_size, e.reference_total,
                out_data.status, out_data.moved_count, out_data.active_size,
                out_data.inactive_size, out_data.reference_total);
          end
        end
      end
    end
    pending <= expected_q.size();
  end
endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  aipr_pkg::in_word_t in_data;
  aipr_pkg::out_word_t out_data;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, pending;
  int idle_cycles;
  bit long_hold;
  bit stim_done;

  active_inactive_page_reclaim_unit u_dut (.*);
  reclaim_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_pages(int unsigned v);
    @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= aipr_pkg::REG_PAGE_COUNT; pwdata <= v; penable <= 0;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_word(logic [1:0] k, logic [7:0] p);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{kind: k, page_id: p};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_out();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_page(int unsigned n);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return (n == 0) ? 8'd0 : 8'($urandom_range(0, (n > 256 ? 256 : n) - 1));
  endfunction

  task automatic random_phase(int unsigned n, int cnt);
    int r;
    for (int i = 0; i < cnt; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_word(aipr_pkg::KIND_ACCESS, pick_page(n));
      else if (r < 82) send_word(aipr_pkg::KIND_SCAN, 8'($urandom));
      else if (r < 97) send_word(aipr_pkg::KIND_READ, pick_page(n));
      else send_word(aipr_pkg::KIND_UNUSED, 8'($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else if (long_hold) out_stall <= 1;
    else out_stall <= ($urandom_range(0, 99) < 25);
  end

  initial begin
    long_hold = 0;
    wait (stim_done == 0 && !rst);
    repeat (3000) @(posedge clk);
    long_hold = 1;
    repeat (300) @(posedge clk);
    long_hold = 0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1; in_valid = 0; in_data = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    stim_done = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    repeat (400) @(posedge clk);
    send_word(aipr_pkg::KIND_READ, 8'd255);
    send_word(aipr_pkg::KIND_ACCESS, 8'd0);
    send_word(aipr_pkg::KIND_ACCESS, 8'd255);
    send_word(aipr_pkg::KIND_ACCESS, 8'd0);
    send_word(aipr_pkg::KIND_SCAN, 8'hff);
    send_word(aipr_pkg::KIND_READ, 8'd0);
    send_word(aipr_pkg::KIND_UNUSED, 8'haa);
    drain_out();
    write_pages(0);
    repeat (20) @(posedge clk);
    send_word(aipr_pkg::KIND_ACCESS, 8'd0);
    send_word(aipr_pkg::KIND_READ, 8'd0);
    send_word(aipr_pkg::KIND_SCAN, 8'd0);
    drain_out();
    write_pages(2);
    repeat (20) @(posedge clk);
    send_word(aipr_pkg::KIND_ACCESS, 8'd0);
    send_word(aipr_pkg::KIND_ACCESS, 8'd1);
    send_word(aipr_pkg::KIND_ACCESS, 8'd2);
    send_word(aipr_pkg::KIND_SCAN, 8'd0);
    send_word(aipr_pkg::KIND_ACCESS, 8'd1);
    send_word(aipr_pkg::KIND_SCAN, 8'd0);
    send_word(aipr_pkg::KIND_READ, 8'd1);
    drain_out();
    write_pages(511);
    repeat (600) @(posedge clk);
    random_phase(511, 120);
    drain_out();
    write_pages(10);
    repeat (40) @(posedge clk);
    random_phase(10, 200);
    drain_out();
    write_pages(5);
    repeat (40) @(posedge clk);
    random_phase(5, 150);
    drain_out();
    write_pages(40);
    repeat (80) @(posedge clk);
    random_phase(40, 230);
    stim_done = 1;
    drain_out();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
